### hw/rtl/lkvc_pkg.sv
// Shared constants and types for the LRU key-value cache.
// No dependencies; imported by lkvc_lookup, lru_key_value_cache and the test files.
package lkvc_pkg;

   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int CAP_W       = 5;
   localparam int DEF_ENTRIES = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   // Request opcodes.
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // Outcome of the lookup for the item in the input register.
   typedef struct packed {
      logic hit;    // key matched a valid entry
      logic fill;   // put of an absent key that takes a free slot
   } lkvc_status_type;

endpackage

### hw/rtl/lkvc_lookup.sv
// Parallel key compare and slot selection for the LRU key-value cache.
// Depends on lkvc_pkg for widths, opcodes and the status struct.
module lkvc_lookup import lkvc_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES,
   parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
   input  logic                     cmd,
   input  logic [KEY_W-1:0]         key,
   input  logic [ENTRIES-1:0]       valid,
   input  logic [KEY_W-1:0]         keys [ENTRIES],
   input  logic [RANK_W-1:0]        ranks [ENTRIES],
   input  logic [CNT_W-1:0]         count,
   input  logic                     room,
   output logic [ENTRIES-1:0]       sel_oh,
   output lkvc_status_type          status
);

   logic [ENTRIES-1:0] match;
   logic [ENTRIES-1:0] empty;
   logic [ENTRIES-1:0] free_oh;
   logic [ENTRIES-1:0] victim_oh;
   logic [CNT_W-1:0]   oldest;

   assign oldest = count - CNT_W'(1);

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]     = valid[i] && (keys[i] == key);
         // Ranks of valid entries are distinct, so exactly one holds count-1.
         victim_oh[i] = valid[i] && (CNT_W'(ranks[i]) == oldest);
      end
   end

   // Lowest-numbered empty slot.
   assign empty   = ~valid;
   assign free_oh = empty & (~empty + ENTRIES'(1));

   assign status.hit  = |match;
   assign status.fill = !status.hit && (cmd == CMD_PUT) && room;

   always_comb begin
      if (status.hit) begin
         sel_oh = match;
      end else if (status.fill) begin
         sel_oh = free_oh;
      end else begin
         sel_oh = victim_oh;
      end
   end

endmodule

### hw/rtl/lru_key_value_cache.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg and instantiates lkvc_lookup.
//
// Usage:
//   The request channel (req_valid/req_ready) carries one word per item:
//   a command (get or put), a 32-bit key and, for a put, a 32-bit value.
//   A get produces one word on the response channel (rsp_valid/rsp_ready)
//   with a hit flag and the stored value, or zero on a miss. A put
//   produces no response. The csr channel writes the capacity register;
//   it is always ready and should only be written while the cache is idle.
//   A capacity of zero acts as one, and one above ENTRIES acts as ENTRIES.
//
//   An accepted item sits in the input register while all entries compare
//   its key in parallel and the recency ranks update; a get response then
//   moves into the response register. One item per cycle is sustained
//   while gets are not held up by the response side; the compare and rank
//   update across all entries set that rate.
//
//   Reset clears all valid bits, ranks and the entry count and sets the
//   capacity to 16; there is no clearing pass. When the receiver stalls,
//   puts keep draining, and a get waits in the input register until the
//   response register is free, which then holds off new requests.
module lru_key_value_cache import lkvc_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic signed [KEY_W-1:0]  req_lookup_key,
   input  logic signed [VAL_W-1:0]  req_store_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_hit,
   output logic signed [VAL_W-1:0]  rsp_read_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_W-1:0]         csr_cache_capacity
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   // Input register.
   logic               s1_vld_ff;
   logic               s1_cmd_ff;
   logic [KEY_W-1:0]   s1_key_ff;
   logic [VAL_W-1:0]   s1_val_ff;

   // Cache state.
   logic [KEY_W-1:0]   keys_ff   [ENTRIES];
   logic [VAL_W-1:0]   values_ff [ENTRIES];
   logic [RANK_W-1:0]  rank_ff   [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CAP_W-1:0]   cap_ff;

   // Response register.
   logic               rsp_vld_ff;
   logic               rsp_hit_ff;
   logic [VAL_W-1:0]   rsp_val_ff;

   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   eff_cap;
   logic               room;
   logic               fire;
   logic               is_put;
   logic               upd;
   logic [ENTRIES-1:0] sel_oh;
   lkvc_status_type    st;
   logic [RANK_W-1:0]  sel_rank;
   logic [VAL_W-1:0]   sel_value;
   logic [CNT_W-1:0]   thresh;

   assign cap_ext = CMP_W'(cap_ff);

   always_comb begin
      if (cap_ext == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         eff_cap = CMP_W'(ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign room = CMP_W'(count_ff) < eff_cap;

   lkvc_lookup #(
      .ENTRIES (ENTRIES),
      .RANK_W  (RANK_W),
      .CNT_W   (CNT_W)
   ) u_lookup (
      .cmd    (s1_cmd_ff),
      .key    (s1_key_ff),
      .valid  (valid_ff),
      .keys   (keys_ff),
      .ranks  (rank_ff),
      .count  (count_ff),
      .room   (room),
      .sel_oh (sel_oh),
      .status (st)
   );

   // A put never waits on the response side; a get needs the response
   // register free or being emptied this cycle.
   assign is_put    = (s1_cmd_ff == CMD_PUT);
   assign fire      = s1_vld_ff && (is_put || !rsp_vld_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || fire;
   assign upd       = fire && (st.hit || is_put);
   assign csr_ready = 1'b1;

   always_comb begin
      sel_rank  = '0;
      sel_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (sel_oh[i]) begin
            sel_rank  = sel_rank | rank_ff[i];
            sel_value = sel_value | values_ff[i];
         end
      end
   end

   // Entries more recent than this threshold age by one place.
   always_comb begin
      if (st.hit) begin
         thresh = CNT_W'(sel_rank);
      end else if (st.fill) begin
         thresh = count_ff;
      end else begin
         thresh = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         s1_vld_ff <= 1'b1;
      end else if (fire) begin
         s1_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff <= req_cmd;
         s1_key_ff <= req_lookup_key;
         s1_val_ff <= req_store_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_cache_capacity;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (upd) begin
         if (st.fill) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (sel_oh[i]) begin
               rank_ff[i] <= '0;
               if (st.fill) begin
                  valid_ff[i] <= 1'b1;
               end
            end else if (valid_ff[i] && (CNT_W'(rank_ff[i]) < thresh)) begin
               rank_ff[i] <= rank_ff[i] + RANK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_put) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (sel_oh[i]) begin
               values_ff[i] <= s1_val_ff;
               if (!st.hit) begin
                  keys_ff[i] <= s1_key_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (fire && !is_put) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !is_put) begin
         rsp_hit_ff <= st.hit;
         rsp_val_ff <= st.hit ? sel_value : '0;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_val_ff;

   // The fill count always equals the number of valid entries.
   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("entry count does not match valid bits");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= ENTRIES)
      else $error("entry count exceeds the number of entries");

   // Any state update targets exactly one slot.
   a_sel_onehot: assert property (@(posedge clock) disable iff (reset)
      upd |-> $onehot(sel_oh))
      else $error("slot selection is not one-hot");

   // A get that completes lookup shows up on the response channel next cycle.
   a_get_responds: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_put) |=> rsp_vld_ff)
      else $error("get did not produce a response");

   // A miss always reports a zero value.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_hit_ff) |-> (rsp_val_ff == '0))
      else $error("miss response carries a nonzero value");

endmodule

### test/lkvc_cache_checker.sv
// Response checker for the LRU key-value cache: keeps its own copy of the entries and their
// recency order from the accepted request words and compares every response word.
// Depends on lkvc_pkg; instantiated by tb_lru_key_value_cache beside the cache.
module lkvc_cache_checker import lkvc_pkg::*; #(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_cmd,
   input  logic signed [KEY_W-1:0] req_lookup_key,
   input  logic signed [VAL_W-1:0] req_store_value,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_hit,
   input  logic signed [VAL_W-1:0] rsp_read_value,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  logic [CAP_W-1:0]        csr_cache_capacity,
   output int                      fail_count,
   output int                      pending_lookups,
   output int                      hit_count,
   output int                      miss_count,
   output int                      evict_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                    hit;
      logic signed [VAL_W-1:0] value;
   } lookup_word_type;

   logic signed [KEY_W-1:0] slot_key   [ENTRIES];
   logic signed [VAL_W-1:0] slot_value [ENTRIES];
   bit                      slot_used  [ENTRIES];
   int unsigned             slot_age   [ENTRIES];
   int unsigned             used_count = 0;
   logic [CAP_W-1:0]        capacity = CAP_RESET;
   lookup_word_type         lookups_due [$];
   int                      fails = 0;
   int                      hits = 0;
   int                      misses = 0;
   int                      evicts = 0;

   // Slot s becomes the most recent; valid slots younger than its old age grow one older.
   function automatic void make_most_recent(int s, int unsigned old_age);
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_used[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
      end
      slot_age[s] = 0;
   endfunction

   function automatic void apply_request(logic cmd, logic signed [KEY_W-1:0] key,
                                         logic signed [VAL_W-1:0] value);
      int              found;
      int              free_slot;
      int              victim;
      int unsigned     limit;
      int unsigned     oldest;
      lookup_word_type word;
      found = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_used[i] && slot_key[i] == key) found = i;
      end
      if (cmd == CMD_GET) begin
         word.hit   = (found >= 0);
         word.value = '0;
         if (found >= 0) begin
            word.value = slot_value[found];
            make_most_recent(found, slot_age[found]);
            hits++;
         end else begin
            misses++;
         end
         lookups_due.push_back(word);
      end else if (found >= 0) begin
         slot_value[found] = value;
         make_most_recent(found, slot_age[found]);
      end else begin
         limit = (capacity == 0) ? 1 : (capacity > ENTRIES) ? ENTRIES : capacity;
         free_slot = -1;
         if (used_count < limit) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (free_slot < 0 && !slot_used[i]) free_slot = i;
            end
         end
         if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_used[i]) slot_age[i]++;
            end
            slot_used[free_slot]  = 1'b1;
            slot_key[free_slot]   = key;
            slot_value[free_slot] = value;
            slot_age[free_slot]   = 0;
            used_count++;
         end else begin
            // No room: the oldest valid slot takes the new pair, the count stays put.
            victim = -1;
            oldest = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_used[i] && (victim < 0 || slot_age[i] > oldest)) begin
                  victim = i;
                  oldest = slot_age[i];
               end
            end
            if (victim >= 0) begin
               slot_key[victim]   = key;
               slot_value[victim] = value;
               make_most_recent(victim, oldest);
               evicts++;
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      lookup_word_type due;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_used[i] = 1'b0;
            slot_age[i]  = 0;
         end
         used_count = 0;
         capacity   = CAP_RESET;
         lookups_due.delete();
      end else begin
         // Responses first: a word leaving now always belongs to an earlier lookup.
         if (rsp_valid && rsp_ready) begin
            if (lookups_due.size() == 0) begin
               $error("response word with no lookup outstanding: hit %0b, read_value %0d",
                      rsp_hit, rsp_read_value);
               fails++;
            end else begin
               due = lookups_due.pop_front();
               if (rsp_hit !== due.hit) begin
                  $error("hit: expected %0b, actual %0b", due.hit, rsp_hit);
                  fails++;
               end
               if (rsp_read_value !== due.value) begin
                  $error("read_value: expected %0d, actual %0d", due.value, rsp_read_value);
                  fails++;
               end
            end
         end
         if (csr_valid && csr_ready) capacity = csr_cache_capacity;
         if (req_valid && req_ready) apply_request(req_cmd, req_lookup_key, req_store_value);
      end
      fail_count      <= fails;
      pending_lookups <= lookups_due.size();
      hit_count       <= hits;
      miss_count      <= misses;
      evict_count     <= evicts;
   end

endmodule

### test/tb_lru_key_value_cache.sv
// Top of the LRU key-value cache testbench: clock, reset, request and capacity stimulus,
// response back-pressure, a stall watchdog and the verdict.
// Depends on lkvc_pkg, lru_key_value_cache and lkvc_cache_checker.
module tb_lru_key_value_cache;
   timeunit 1ns;
   timeprecision 1ps;
   import lkvc_pkg::*;

   localparam int ENTRIES     = DEF_ENTRIES;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 200;
   localparam int POOL_SIZE   = 32;

   localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
   localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_cmd = CMD_GET;
   logic signed [KEY_W-1:0] req_lookup_key = '0;
   logic signed [VAL_W-1:0] req_store_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_hit;
   logic signed [VAL_W-1:0] rsp_read_value;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CAP_W-1:0]        csr_cache_capacity = CAP_RESET;

   int fail_count;
   int pending_lookups;
   int hit_count;
   int miss_count;
   int evict_count;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int pressure_seq = 0;
   int pressure_seen = 0;
   int hold_left = 0;
   int request_total = 0;
   int stall_cycles = 0;
   logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

   lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_lookup_key     (req_lookup_key),
      .req_store_value    (req_store_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_read_value     (rsp_read_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_cache_capacity (csr_cache_capacity)
   );

   lkvc_cache_checker #(.ENTRIES(ENTRIES)) u_cache_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_lookup_key     (req_lookup_key),
      .req_store_value    (req_store_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_read_value     (rsp_read_value),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_cache_capacity (csr_cache_capacity),
      .fail_count         (fail_count),
      .pending_lookups    (pending_lookups),
      .hit_count          (hit_count),
      .miss_count         (miss_count),
      .evict_count        (evict_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side. A new pressure request holds ready low for a long stretch.
   always @(posedge clock) begin
      if (pressure_seen != pressure_seq) begin
         pressure_seen = pressure_seq;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("No word moved on any channel for %0d cycles.", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_request(logic cmd, logic signed [KEY_W-1:0] key,
                               logic signed [VAL_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_lookup_key  <= key;
      req_store_value <= value;
      do @(posedge clock); while (!req_ready);
      request_total++;
   endtask

   task automatic send_random(int pool_n, int put_pct);
      logic signed [KEY_W-1:0] key;
      // Mostly keys from a small pool so that hits and evictions are common.
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_n - 1)];
      else key = $urandom;
      send_request(($urandom_range(99) < put_pct) ? CMD_PUT : CMD_GET, key, $urandom);
   endtask

   // Wait until every lookup has answered; a put may still be in the input register.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_lookups != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_valid          <= 1'b1;
      csr_cache_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CAP_W-1:0] phase_cap [7];
      int               usable;
      phase_cap = '{5'd3, 5'd0, 5'd31, 5'd1, 5'd7, 5'd16, 5'd12};
      key_pool[0] = '0;
      key_pool[1] = -1;
      key_pool[2] = KEY_MIN;
      key_pool[3] = KEY_MAX;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(CMD_GET, 0, 0);
      send_request(CMD_PUT, KEY_MAX, VAL_MIN);
      send_request(CMD_PUT, KEY_MIN, VAL_MAX);
      send_request(CMD_PUT, -1, -1);
      send_request(CMD_PUT, 0, 0);
      send_request(CMD_GET, KEY_MAX, -1);
      send_request(CMD_GET, KEY_MIN, VAL_MAX);
      send_request(CMD_GET, -1, 0);
      send_request(CMD_GET, 0, 0);
      send_request(CMD_PUT, -1, 32'sd12345);
      send_request(CMD_GET, -1, 0);
      send_request(CMD_GET, 1, 0);
      settle();

      // Four entries live, capacity dropped to three: new keys must replace the oldest.
      write_capacity(5'd3);
      send_request(CMD_PUT, 32'sd77, 32'sd1);
      send_request(CMD_GET, 32'sd77, 0);
      send_request(CMD_GET, KEY_MAX, 0);
      send_request(CMD_GET, KEY_MIN, 0);
      send_request(CMD_PUT, 32'sd78, 32'sd2);
      send_request(CMD_GET, -1, 0);
      settle();

      for (int p = 0; p < 7; p++) begin
         tx_idle_pct = (p < 2) ? 26 : (p < 4) ? 69 : 0;
         rx_idle_pct = (p < 2) ? 69 : (p < 4) ? 26 : 0;
         write_capacity(phase_cap[p]);
         usable = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > ENTRIES) ? ENTRIES : phase_cap[p];
         if (usable + 4 > POOL_SIZE) usable = POOL_SIZE - 4;
         if (p == 5) pressure_seq++;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random(usable + 4, (p == 5 && n < 60) ? 20 : 45);
         end
         settle();
      end

      $display("Sent %0d request words: %0d lookups (%0d hits, %0d misses), %0d evictions.",
               request_total, hit_count + miss_count, hit_count, miss_count, evict_count);
      $display("Capacities 0, 1, 3, 7, 12, 16 and 31 ran under three idle patterns");
      $display("and a %0d-cycle response hold.", HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
